>>> rtl/core/sdcp_pkg.sv
`default_nettype none
package sdcp_pkg;
  localparam int FifoDepth = 16;
  localparam int CountW = $clog2(FifoDepth + 1);
  localparam int IdxW = $clog2(FifoDepth);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [3:0] PORT_RESET = 4'h6;
  localparam logic [3:0] PORT_READ = 4'hA;
  localparam logic [3:0] PORT_CMD = 4'hC;
  localparam logic [3:0] PORT_AVAIL = 4'hE;

  localparam logic [16:0] LenMask = 17'h1FFFF;

  typedef enum logic [2:0] {
    K_NOP = 3'd0,
    K_WRITE = 3'd1,
    K_RESET = 3'd2,
    K_POP = 3'd3,
    K_RDCONST = 3'd4,
    K_AVAIL = 3'd5,
    K_TICK = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] value;
  } item_t;

  function automatic logic [7:0] ident_byte(input logic [7:0] v);
    logic signed [15:0] acc;
    acc = 16'sd170 - 16'sd106;
    if (v[0]) acc = acc + 16'sd1;
    if (v[1]) acc = acc - 16'sd2;
    if (v[2]) acc = acc - 16'sd4;
    if (v[3]) acc = acc + 16'sd8;
    if (v[4]) acc = acc - 16'sd16;
    if (v[5]) acc = acc + 16'sd32;
    if (v[6]) acc = acc + 16'sd64;
    if (v[7]) acc = acc - 16'sd128;
    return acc[7:0];
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/sdcp_front.sv
`default_nettype none
module sdcp_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid,
  output logic ready,
  input  wire logic [1:0] opcode,
  input  wire logic [3:0] port,
  input  wire logic [7:0] write_value,
  input  wire logic [7:0] dma_byte,
  output logic q_valid,
  input  wire logic q_ready,
  output sdcp_pkg::item_t q_item
);
  import sdcp_pkg::*;
  item_t cls;
  item_t slot [2];
  logic [1:0] fill;
  logic wp, rp;

  always_comb begin
    cls.value = write_value;
    cls.kind = K_NOP;
    case (opcode)
      OP_WRITE: begin
        if (port == PORT_RESET && write_value == 8'h00) cls.kind = K_RESET;
        else if (port == PORT_CMD) cls.kind = K_WRITE;
      end
      OP_READ: begin
        if (port == PORT_READ) cls.kind = K_POP;
        else if (port == PORT_AVAIL) cls.kind = K_AVAIL;
        else begin
          cls.kind = K_RDCONST;
          cls.value = (port == PORT_CMD) ? 8'h00 : 8'hFF;
        end
      end
      OP_TICK: begin
        cls.kind = K_TICK;
        cls.value = dma_byte;
      end
      default: cls.kind = K_NOP;
    endcase
  end

  assign ready = (fill != 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_item = slot[rp];

  always_ff @(posedge clk) begin
    if (valid && ready) slot[wp] <= cls;
    if (rst) begin
      fill <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (valid && ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      fill <= fill + {1'b0, valid && ready} - {1'b0, q_valid && q_ready};
    end
  end

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue overfilled");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2 && !q_ready) |=> fill == 2'd2)
    else $error("queue lost an item");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 || fill == 2'd2) |-> wp == rp)
    else $error("pointer mismatch");
`endif
endmodule
`default_nettype wire

>>> rtl/core/sdcp_back.sv
`default_nettype none
module sdcp_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic q_ready,
  input  wire sdcp_pkg::item_t q_item,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [7:0] read_data,
  output logic signed [15:0] sample_out,
  output logic irq_pulse,
  output logic dma_write_valid,
  output logic [7:0] dma_write_data,
  output logic dma_read_taken,
  output logic timer_running,
  output logic [7:0] time_constant
);
  import sdcp_pkg::*;
  logic [7:0] fifo [FifoDepth];
  logic [CountW-1:0] count;
  logic [7:0] pending;
  logic hb;
  logic [16:0] blen, bcnt;
  logic silence, autoinit, record, active, speaker;
  logic [7:0] test_reg, tc;
  logic [15:0] sample;
  logic ten;

  logic [7:0] fifo_next [FifoDepth];
  logic [CountW-1:0] count_next;
  logic [7:0] pending_next;
  logic hb_next;
  logic [16:0] blen_next, bcnt_next, cnt_inc;
  logic silence_next, autoinit_next, record_next, active_next, speaker_next;
  logic [7:0] test_next, tc_next;
  logic [15:0] sample_next;
  logic ten_next;
  logic [7:0] rd;
  logic irq, dwv, taken;
  logic [7:0] dwd;
  logic [7:0] v;
  logic go, lenhi;
  logic [16:0] lensum;
  logic push1, push2;
  logic [7:0] pv1, pv2;

  assign v = q_item.value;
  assign q_ready = !out_valid || out_ready;
  assign go = q_valid && q_ready;
  assign lensum = (({9'd0, blen[7:0]} | {1'b0, v, 8'd0}) + 17'd1) & LenMask;
  assign cnt_inc = (bcnt + 17'd1) & LenMask;

  always_comb begin
    fifo_next = fifo;
    count_next = count;
    pending_next = pending;
    hb_next = hb;
    blen_next = blen;
    bcnt_next = bcnt;
    silence_next = silence;
    autoinit_next = autoinit;
    record_next = record;
    active_next = active;
    speaker_next = speaker;
    test_next = test_reg;
    tc_next = tc;
    sample_next = sample;
    ten_next = ten;
    rd = 8'h00;
    irq = 1'b0;
    dwv = 1'b0;
    dwd = 8'h00;
    taken = 1'b0;
    push1 = 1'b0;
    push2 = 1'b0;
    pv1 = 8'h00;
    pv2 = 8'h00;
    lenhi = 1'b0;
    case (q_item.kind)
      K_RESET: begin
        speaker_next = 1'b0;
        sample_next = '0;
        count_next = '0;
        push1 = 1'b1;
        pv1 = 8'hAA;
      end
      K_WRITE: begin
        case (pending)
          8'h10: begin
            sample_next = {v ^ 8'h80, 8'h00};
            pending_next = 8'h00;
          end
          8'h14, 8'h24, 8'h48, 8'h80: begin
            if (!hb) begin
              blen_next = {9'd0, v};
              hb_next = 1'b1;
            end else begin
              blen_next = lensum;
              lenhi = 1'b1;
              pending_next = 8'h00;
              if (pending != 8'h48) begin
                bcnt_next = '0;
                silence_next = (pending == 8'h80);
                autoinit_next = 1'b0;
                ten_next = 1'b1;
                if (pending != 8'h80) begin
                  record_next = (pending == 8'h24);
                  active_next = 1'b1;
                end
              end
            end
          end
          8'h40: begin
            tc_next = v;
            pending_next = 8'h00;
          end
          8'hE0: begin
            push1 = 1'b1;
            pv1 = ~v;
            pending_next = 8'h00;
          end
          8'hE2: begin
            dwv = 1'b1;
            dwd = ident_byte(v);
            pending_next = 8'h00;
          end
          8'hE4: begin
            test_next = v;
            pending_next = 8'h00;
          end
          default: begin
            pending_next = v;
            case (v)
              8'h14, 8'h24, 8'h48, 8'h80: hb_next = 1'b0;
              8'h1C, 8'h2C: begin
                bcnt_next = '0;
                silence_next = 1'b0;
                autoinit_next = 1'b1;
                record_next = (v == 8'h2C);
                active_next = 1'b1;
                ten_next = 1'b1;
              end
              8'h20: begin
                push1 = 1'b1;
                pv1 = 8'h80;
              end
              8'hD0: begin
                active_next = 1'b0;
                ten_next = 1'b0;
              end
              8'hD1: speaker_next = 1'b1;
              8'hD3: speaker_next = 1'b0;
              8'hD4: begin
                active_next = 1'b1;
                ten_next = 1'b1;
              end
              8'hDA: begin
                active_next = 1'b0;
                autoinit_next = 1'b0;
              end
              8'hE1: begin
                push1 = 1'b1;
                pv1 = 8'h02;
                push2 = 1'b1;
                pv2 = 8'h01;
              end
              8'hE8: begin
                push1 = 1'b1;
                pv1 = test_reg;
              end
              8'hF2: irq = 1'b1;
              8'hF8: begin
                push1 = 1'b1;
                pv1 = 8'h00;
              end
              default: ;
            endcase
          end
        endcase
      end
      K_POP: begin
        rd = fifo[0];
        if (count != '0) count_next = count - 1'b1;
        for (int i = 0; i < FifoDepth - 1; i++) fifo_next[i] = fifo[i+1];
      end
      K_RDCONST: rd = v;
      K_AVAIL: rd = (count != '0) ? 8'h80 : 8'h00;
      K_TICK: begin
        if (ten) begin
          if (!silence) begin
            if (!record) begin
              sample_next = {v ^ 8'h80, 8'h00};
              taken = 1'b1;
            end else begin
              dwv = 1'b1;
              dwd = 8'h80;
            end
          end else begin
            sample_next = '0;
          end
          bcnt_next = cnt_inc;
          if (cnt_inc == blen) begin
            bcnt_next = '0;
            irq = 1'b1;
            if (!autoinit) begin
              active_next = 1'b0;
              ten_next = 1'b0;
            end
          end
          if (!speaker) sample_next = '0;
        end
      end
      default: ;
    endcase
    if (push1 && count_next < CountW'(FifoDepth)) begin
      fifo_next[count_next[IdxW-1:0]] = pv1;
      count_next = count_next + 1'b1;
    end
    if (push2 && count_next < CountW'(FifoDepth)) begin
      fifo_next[count_next[IdxW-1:0]] = pv2;
      count_next = count_next + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      read_data <= rd;
      irq_pulse <= irq;
      dma_write_valid <= dwv;
      dma_write_data <= dwd;
      dma_read_taken <= taken;
      sample_out <= sample_next;
      timer_running <= ten_next;
      time_constant <= tc_next;
    end
    if (rst) begin
      out_valid <= 1'b0;
      fifo <= '{default: 8'h00};
      count <= '0;
      pending <= '0;
      hb <= 1'b0;
      blen <= '0;
      bcnt <= '0;
      silence <= 1'b0;
      autoinit <= 1'b0;
      record <= 1'b0;
      active <= 1'b0;
      speaker <= 1'b0;
      test_reg <= '0;
      tc <= '0;
      sample <= '0;
      ten <= 1'b0;
    end else begin
      if (go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (go) begin
        fifo <= fifo_next;
        count <= count_next;
        pending <= pending_next;
        hb <= hb_next;
        blen <= blen_next;
        bcnt <= bcnt_next;
        silence <= silence_next;
        autoinit <= autoinit_next;
        record <= record_next;
        active <= active_next;
        speaker <= speaker_next;
        test_reg <= test_next;
        tc <= tc_next;
        sample <= sample_next;
        ten <= ten_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(FifoDepth))
    else $error("reply count out of range");
  a_len: assert property (@(posedge clk) disable iff (rst)
    (go && lenhi) |=> !hb || $past(hb))
    else $error("length collector phase lost");
  a_dma: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(dma_write_valid && dma_read_taken))
    else $error("tick both read and wrote DMA");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(sample))
    else $error("state moved during stall");
`endif
endmodule
`default_nettype wire

>>> rtl/core/sound_dsp_command_port.sv
// Command port of an 8-bit sound DSP. Each item is a port write, a port read or a
// sample tick, and each gives exactly one result item carrying the read byte, the
// current sample, the interrupt pulse, the DMA strobes, the timer state and the
// time constant. Unless stalled, one item is taken per clock: a two-entry queue
// separates the input classifier from the executing stage, whose output register holds the result.
`default_nettype none
module sound_dsp_command_port (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [3:0] port,
  input  wire logic [7:0] write_value,
  input  wire logic [7:0] dma_byte,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [7:0] read_data,
  output logic signed [15:0] sample_out,
  output logic irq_pulse,
  output logic dma_write_valid,
  output logic [7:0] dma_write_data,
  output logic dma_read_taken,
  output logic timer_running,
  output logic [7:0] time_constant
);
  import sdcp_pkg::*;
  logic q_valid, q_ready;
  item_t q_item;

  sdcp_front u_front (
    .clk, .rst, .valid(in_valid), .ready(in_ready),
    .opcode, .port, .write_value, .dma_byte,
    .q_valid, .q_ready, .q_item
  );

  sdcp_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .read_data, .sample_out, .irq_pulse,
    .dma_write_valid, .dma_write_data, .dma_read_taken,
    .timer_running, .time_constant
  );
endmodule
`default_nettype wire

>>> sim/tb_sound_dsp_command_port.sv
`default_nettype none
module tb_sound_dsp_command_port;
  import sdcp_pkg::*;

  localparam logic [7:0] CMD_DAC = 8'h10;
  localparam logic [7:0] CMD_PLAY = 8'h14;
  localparam logic [7:0] CMD_PLAY_AUTO = 8'h1C;
  localparam logic [7:0] CMD_RDSAMPLE = 8'h20;
  localparam logic [7:0] CMD_REC = 8'h24;
  localparam logic [7:0] CMD_REC_AUTO = 8'h2C;
  localparam logic [7:0] CMD_TCONST = 8'h40;
  localparam logic [7:0] CMD_BLKSIZE = 8'h48;
  localparam logic [7:0] CMD_SILENCE = 8'h80;
  localparam logic [7:0] CMD_HALT = 8'hD0;
  localparam logic [7:0] CMD_SPK_ON = 8'hD1;
  localparam logic [7:0] CMD_SPK_OFF = 8'hD3;
  localparam logic [7:0] CMD_CONTINUE = 8'hD4;
  localparam logic [7:0] CMD_EXIT_AUTO = 8'hDA;
  localparam logic [7:0] CMD_INVERT = 8'hE0;
  localparam logic [7:0] CMD_VERSION = 8'hE1;
  localparam logic [7:0] CMD_IDENT = 8'hE2;
  localparam logic [7:0] CMD_WRTEST = 8'hE4;
  localparam logic [7:0] CMD_RDTEST = 8'hE8;
  localparam logic [7:0] CMD_IRQ = 8'hF2;
  localparam logic [7:0] CMD_PUSH0 = 8'hF8;
  localparam logic [7:0] RESET_REPLY = 8'hAA;
  localparam logic [4:0] MF_SILENCE = 5'h01;
  localparam logic [4:0] MF_AUTOINIT = 5'h02;
  localparam logic [4:0] MF_RECORD = 5'h04;
  localparam logic [4:0] MF_ACTIVE = 5'h08;
  localparam logic [4:0] MF_SPEAKER = 5'h10;
  localparam int LIMIT = 300000;

  typedef struct {
    logic [7:0] rd;
    logic [15:0] sample;
    logic irq;
    logic dwv;
    logic [7:0] dwd;
    logic taken;
    logic running;
    logic [7:0] tc;
  } dsp_result_t;

  class dsp_scoreboard;
    logic [7:0] replies[FifoDepth];
    int unsigned reply_cnt;
    logic [7:0] pend;
    bit hi_next;
    logic [16:0] blen, bcnt;
    logic [4:0] mf;
    logic [7:0] testr, tconst;
    logic [15:0] samp;
    bit ten;
    dsp_result_t awaited[$];
    int errors;
    dsp_result_t r;

    function new();
      foreach (replies[i]) replies[i] = 8'h00;
      reply_cnt = 0; pend = 0; hi_next = 0; blen = 0; bcnt = 0; mf = 0;
      testr = 0; tconst = 0; samp = 0; ten = 0; errors = 0;
    endfunction

    function void push_reply(logic [7:0] v);
      if (reply_cnt < FifoDepth) begin
        replies[reply_cnt] = v;
        reply_cnt++;
      end
    endfunction

    function logic [7:0] pop_reply();
      logic [7:0] head;
      head = replies[0];
      if (reply_cnt > 0) reply_cnt--;
      for (int i = 0; i < FifoDepth - 1; i++) replies[i] = replies[i + 1];
      return head;
    endfunction

    function bit collect_len(logic [7:0] v);
      if (!hi_next) begin
        blen = {9'd0, v};
        hi_next = 1;
        return 0;
      end
      blen = ((blen | {1'b0, v, 8'h00}) + 17'd1) & LenMask;
      return 1;
    endfunction

    function void start_block(bit sil, bit ai, bit rec, bit set_act);
      bcnt = 0;
      mf = mf & ~(MF_SILENCE | MF_AUTOINIT);
      if (sil) mf = mf | MF_SILENCE;
      if (ai) mf = mf | MF_AUTOINIT;
      if (set_act) begin
        mf = mf & ~MF_RECORD;
        if (rec) mf = mf | MF_RECORD;
        mf = mf | MF_ACTIVE;
      end
      ten = 1;
    endfunction

    function void cmd_write(logic [7:0] v);
      logic [7:0] pc;
      int acc;
      pc = pend;
      case (pc)
        CMD_DAC: begin
          samp = {v ^ 8'h80, 8'h00};
          pend = 0;
          return;
        end
        CMD_PLAY, CMD_REC: begin
          if (collect_len(v)) begin
            pend = 0;
            start_block(0, 0, pc == CMD_REC, 1);
          end
          return;
        end
        CMD_TCONST: begin
          tconst = v;
          pend = 0;
          return;
        end
        CMD_BLKSIZE: begin
          if (collect_len(v)) pend = 0;
          return;
        end
        CMD_SILENCE: begin
          if (collect_len(v)) begin
            pend = 0;
            start_block(1, 0, 0, 0);
          end
          return;
        end
        CMD_INVERT: begin
          push_reply(~v);
          pend = 0;
          return;
        end
        CMD_IDENT: begin
          acc = 170 - 106;
          if (v[0]) acc += 1;
          if (v[1]) acc -= 2;
          if (v[2]) acc -= 4;
          if (v[3]) acc += 8;
          if (v[4]) acc -= 16;
          if (v[5]) acc += 32;
          if (v[6]) acc += 64;
          if (v[7]) acc -= 128;
          r.dwv = 1;
          r.dwd = acc[7:0];
          pend = 0;
          return;
        end
        CMD_WRTEST: begin
          testr = v;
          pend = 0;
          return;
        end
        default: ;
      endcase
      case (v)
        CMD_PLAY, CMD_REC, CMD_BLKSIZE, CMD_SILENCE: hi_next = 0;
        CMD_PLAY_AUTO, CMD_REC_AUTO: start_block(0, 1, v == CMD_REC_AUTO, 1);
        CMD_RDSAMPLE: push_reply(8'd128);
        CMD_HALT: begin
          mf = mf & ~MF_ACTIVE;
          ten = 0;
        end
        CMD_SPK_ON: mf = mf | MF_SPEAKER;
        CMD_SPK_OFF: mf = mf & ~MF_SPEAKER;
        CMD_CONTINUE: begin
          mf = mf | MF_ACTIVE;
          ten = 1;
        end
        CMD_EXIT_AUTO: mf = mf & ~(MF_ACTIVE | MF_AUTOINIT);
        CMD_VERSION: begin
          push_reply(8'd2);
          push_reply(8'd1);
        end
        CMD_RDTEST: push_reply(testr);
        CMD_IRQ: r.irq = 1;
        CMD_PUSH0: push_reply(8'd0);
        default: ;
      endcase
      pend = v;
    endfunction

    function void sample_tick(logic [7:0] db);
      if (!ten) return;
      if ((mf & MF_SILENCE) == 0) begin
        if ((mf & MF_RECORD) == 0) begin
          samp = {db ^ 8'h80, 8'h00};
          r.taken = 1;
        end else begin
          r.dwv = 1;
          r.dwd = 8'd128;
        end
      end else begin
        samp = 0;
      end
      bcnt = (bcnt + 17'd1) & LenMask;
      if (bcnt == blen) begin
        bcnt = 0;
        r.irq = 1;
        if ((mf & MF_AUTOINIT) == 0) begin
          mf = mf & ~MF_ACTIVE;
          ten = 0;
        end
      end
      if ((mf & MF_SPEAKER) == 0) samp = 0;
    endfunction

    function void note_item(logic [1:0] op, logic [3:0] prt, logic [7:0] wv, logic [7:0] db);
      r.rd = 0; r.irq = 0; r.dwv = 0; r.dwd = 0; r.taken = 0;
      if (op == OP_WRITE) begin
        if (prt == PORT_RESET && wv == 0) begin
          mf = mf & ~MF_SPEAKER;
          samp = 0;
          reply_cnt = 0;
          push_reply(RESET_REPLY);
        end else if (prt == PORT_CMD) begin
          cmd_write(wv);
        end
      end else if (op == OP_READ) begin
        if (prt == PORT_READ) r.rd = pop_reply();
        else if (prt == PORT_CMD) r.rd = 8'h00;
        else if (prt == PORT_AVAIL) r.rd = reply_cnt > 0 ? 8'h80 : 8'h00;
        else r.rd = 8'hFF;
      end else if (op == OP_TICK) begin
        sample_tick(db);
      end
      r.sample = samp;
      r.running = ten;
      r.tc = tconst;
      awaited.push_back(r);
    endfunction

    function void mismatch(string name, logic [15:0] exp_v, logic [15:0] got_v);
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
    endfunction

    function void check_result(dsp_result_t got);
      dsp_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result item: expected none, got rd=%h sample=%h",
                 $time, got.rd, got.sample);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.rd !== e.rd) mismatch("read_data", e.rd, got.rd);
      if (got.sample !== e.sample) mismatch("sample_out", e.sample, got.sample);
      if (got.irq !== e.irq) mismatch("irq_pulse", e.irq, got.irq);
      if (got.dwv !== e.dwv) mismatch("dma_write_valid", e.dwv, got.dwv);
      if (got.dwd !== e.dwd) mismatch("dma_write_data", e.dwd, got.dwd);
      if (got.taken !== e.taken) mismatch("dma_read_taken", e.taken, got.taken);
      if (got.running !== e.running) mismatch("timer_running", e.running, got.running);
      if (got.tc !== e.tc) mismatch("time_constant", e.tc, got.tc);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic [1:0] opcode = 0;
  logic [3:0] port = 0;
  logic [7:0] write_value = 0;
  logic [7:0] dma_byte = 0;
  logic out_ready = 0;
  logic in_ready, out_valid;
  logic [7:0] read_data, dma_write_data, time_constant;
  logic signed [15:0] sample_out;
  logic irq_pulse, dma_write_valid, dma_read_taken, timer_running;

  dsp_scoreboard sb = new();
  bit calm = 0;
  int sent = 0;
  int cycles = 0;
  int stall_left = 0;
  dsp_result_t seen;

  sound_dsp_command_port u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .port(port), .write_value(write_value), .dma_byte(dma_byte),
    .out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
    .sample_out(sample_out), .irq_pulse(irq_pulse), .dma_write_valid(dma_write_valid),
    .dma_write_data(dma_write_data), .dma_read_taken(dma_read_taken),
    .timer_running(timer_running), .time_constant(time_constant)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen.rd = read_data;
        seen.sample = sample_out;
        seen.irq = irq_pulse;
        seen.dwv = dma_write_valid;
        seen.dwd = dma_write_data;
        seen.taken = dma_read_taken;
        seen.running = timer_running;
        seen.tc = time_constant;
        sb.check_result(seen);
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic send(logic [1:0] op, logic [3:0] prt, logic [7:0] wv, logic [7:0] db);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    port <= prt;
    write_value <= wv;
    dma_byte <= db;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, prt, wv, db);
    sent++;
  endtask

  task automatic cmd(logic [7:0] v);
    send(OP_WRITE, PORT_CMD, v, $urandom_range(0, 255));
  endtask

  task automatic rd(logic [3:0] prt);
    send(OP_READ, prt, $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic ticks(int n);
    repeat (n) send(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 255),
                    $urandom_range(0, 255));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic block_len(logic [7:0] c);
    cmd(c);
    cmd($urandom_range(0, 6));
    cmd($urandom_range(0, 15) == 0 ? $urandom_range(0, 1) : 8'd0);
  endtask

  task automatic random_seq();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1: begin
        if ($urandom_range(0, 1)) cmd($urandom_range(0, 1) ? CMD_SPK_ON : CMD_SPK_OFF);
        case ($urandom_range(0, 2))
          0: c = CMD_PLAY;
          1: c = CMD_REC;
          default: c = CMD_SILENCE;
        endcase
        block_len(c);
        ticks($urandom_range(1, 12));
        if ($urandom_range(0, 3) == 0) cmd(CMD_HALT);
      end
      2: begin
        block_len(CMD_BLKSIZE);
        cmd($urandom_range(0, 1) ? CMD_PLAY_AUTO : CMD_REC_AUTO);
        ticks($urandom_range(1, 14));
        cmd($urandom_range(0, 1) ? CMD_EXIT_AUTO : CMD_HALT);
        ticks($urandom_range(0, 3));
      end
      3: begin
        cmd(CMD_DAC);
        cmd($urandom_range(0, 255));
      end
      4: begin
        case ($urandom_range(0, 4))
          0: c = CMD_TCONST;
          1: c = CMD_WRTEST;
          2: c = CMD_INVERT;
          3: c = CMD_IDENT;
          default: c = CMD_DAC;
        endcase
        cmd(c);
        cmd($urandom_range(0, 255));
      end
      5: begin
        case ($urandom_range(0, 6))
          0: c = CMD_VERSION;
          1: c = CMD_RDTEST;
          2: c = CMD_RDSAMPLE;
          3: c = CMD_PUSH0;
          4: c = CMD_IRQ;
          5: c = CMD_CONTINUE;
          default: c = CMD_SPK_ON;
        endcase
        cmd(c);
        if (c == CMD_CONTINUE) begin
          ticks($urandom_range(1, 4));
          cmd(CMD_HALT);
        end
      end
      6: repeat ($urandom_range(1, 4)) rd($urandom_range(0, 2) == 0 ?
                                          $urandom_range(0, 15) : PORT_READ);
      7: send(OP_WRITE, PORT_RESET, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 0,
               $urandom_range(0, 255));
      8: rd($urandom_range(0, 1) ? PORT_AVAIL : PORT_CMD);
      default: send($urandom_range(0, 2), $urandom_range(0, 15), $urandom_range(0, 255),
                    $urandom_range(0, 255));
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rd(PORT_READ);
    send(OP_WRITE, PORT_RESET, 8'h00, 8'h00);
    send(OP_WRITE, PORT_RESET, 8'hFF, 8'hFF);
    rd(PORT_AVAIL);
    rd(PORT_READ);
    rd(PORT_READ);
    rd(PORT_CMD);
    rd(4'h0);
    rd(4'hF);
    cmd(CMD_VERSION);
    cmd(CMD_WRTEST);
    cmd(8'hFF);
    cmd(CMD_RDTEST);
    cmd(CMD_INVERT);
    cmd(8'h00);
    cmd(CMD_IDENT);
    cmd(8'hFF);
    cmd(CMD_TCONST);
    cmd(8'hFF);
    cmd(CMD_DAC);
    cmd(8'h00);
    cmd(CMD_SPK_ON);
    cmd(CMD_PLAY);
    cmd(8'h01);
    cmd(8'h00);
    send(OP_TICK, 4'h0, 8'h00, 8'hFF);
    send(OP_TICK, 4'hF, 8'hFF, 8'h00);
    send(OP_TICK, 4'h0, 8'h00, 8'h55);
    cmd(8'h99);
    cmd(CMD_IRQ);

    calm = 1;
    repeat (20) cmd(CMD_VERSION);
    repeat (20) rd(PORT_READ);
    calm = 0;
    drain();
    repeat ($urandom_range(5, 30)) @(posedge clk);

    while (sent < 680) begin
      if ($urandom_range(0, 40) == 0) calm = !calm;
      random_seq();
    end
    calm = 0;
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
rtl/core/sdcp_pkg.sv
rtl/core/sdcp_front.sv
rtl/core/sdcp_back.sv
rtl/core/sound_dsp_command_port.sv
sim/tb_sound_dsp_command_port.sv
